### design/multichannel_comb_filter_unit_assert.svh
// assertion macros shared by the comb filter rtl
`ifndef MULTICHANNEL_COMB_FILTER_UNIT_ASSERT_SVH
`define MULTICHANNEL_COMB_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MCF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define MCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/mcf_pkg.sv
`timescale 1ns / 1ps
package mcf_pkg;

    localparam int CH_W      = 3;
    localparam int GAIN_W    = 16;
    localparam int DLEN_W    = 11;
    localparam int FRAC_BITS = 14;
    localparam int RND_HALF  = 8192;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_GAIN  = 2'd0,
        REG_DELAY = 2'd1,
        REG_MODE  = 2'd2
    } reg_idx_t;

    localparam logic MODE_FF = 1'b0;
    localparam logic MODE_FB = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [DLEN_W-1:0] delay_length;
        logic              mode;
    } cfg_t;

endpackage

### design/mcf_stream_if.sv
`timescale 1ns / 1ps
interface mcf_in_if
    import mcf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [CH_W-1:0]                channel;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink (input valid, input channel, input sample_in, output ready);
endinterface

interface mcf_out_if
    import mcf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [CH_W-1:0]                channel_out;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;

    modport source (output valid, output channel_out, output sample_out, output saturated,
                    input ready);
    modport sink (input valid, input channel_out, input sample_out, input saturated,
                  output ready);
endinterface

### design/multichannel_comb_filter_unit.sv
`timescale 1ns / 1ps
// Multichannel comb filter, y = x + gain * d per channel, feedforward or feedback.
// din carries one beat per sample (channel, sample_in); dout returns one beat per
// sample (channel_out, sample_out, saturated) in the order taken. Both use
// valid/ready. gain, delay_length and mode sit on the APB port at 0x0, 0x4, 0x8;
// they are to be written only while the block is empty; the block does not check this.
// A beat taken on din passes the read stage, the multiply stage and the output
// register in turn before it shows on dout.
// Throughput: one beat per cycle while dout does not stall and no feedback hazard
// holds the read stage, set by the single read and single write of the delay memory
// each cycle. In feedback mode with a delay of one, the second of two back-to-back
// beats on the same channel waits for the first one's result to land in the delay memory.
// Reset clears the write pointers and the per-channel wrap flags; delay slots
// not yet written since reset read as zero, so no memory clearing pass runs
// and the block takes beats right after reset.
// When dout stalls, the output register holds its beat and the two stages
// behind it keep filling, so din is still taken until all three are full.
module multichannel_comb_filter_unit
    import mcf_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int MAX_DELAY    = 1024,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    mcf_in_if.sink            din,
    mcf_out_if.source         dout
);

    `include "multichannel_comb_filter_unit_assert.svh"

    localparam int SW     = SAMPLE_WIDTH;
    localparam int DEPTH  = CHANNELS * MAX_DELAY;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = GAIN_W + SW;
    localparam int RND_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = RND_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [SW-1:0]    SAT_POS = SAT_HI[SW-1:0];
    localparam logic signed [SW-1:0]    SAT_NEG = SAT_LO[SW-1:0];

    cfg_t cfg;

    mcf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake and stage control
    logic acc;
    logic en3;
    logic move12;
    logic hazard;

    // pointer lookup for the incoming beat
    logic          pt_ch_ok;
    logic          pt_filled;
    logic [AW-1:0] pt_rd_addr;
    logic [AW-1:0] pt_wr_addr;

    // stage 1: memory read in flight
    logic                 s1_valid_reg;
    logic                 s1_ok_reg;
    logic                 s1_filled_reg;
    logic [CH_W-1:0]      s1_ch_reg;
    logic signed [SW-1:0] s1_x_reg;
    logic [AW-1:0]        s1_rd_addr_reg;
    logic [AW-1:0]        s1_wr_addr_reg;
    logic                 byp_hit_reg;
    logic [SW-1:0]        byp_data_reg;
    logic                 byp_hit_next;
    logic [SW-1:0]        byp_data_next;

    // stage 2: product registered
    logic                     s2_valid_reg;
    logic                     s2_ok_reg;
    logic [CH_W-1:0]          s2_ch_reg;
    logic signed [SW-1:0]     s2_x_reg;
    logic [AW-1:0]            s2_wr_addr_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    // stage 3: output register
    logic                 s3_valid_reg;
    logic [CH_W-1:0]      s3_ch_reg;
    logic signed [SW-1:0] s3_y_reg;
    logic                 s3_sat_reg;

    // memory
    logic [SW-1:0] mem_rdata;
    logic          mem_we;
    logic [SW-1:0] mem_wdata;

    // datapath
    logic                     s12_match;
    logic signed [SW-1:0]     d_mem;
    logic signed [SW-1:0]     d_sel;
    logic signed [GAIN_W-1:0] gain_s;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] rnd_full;
    logic signed [RND_W-1:0]  rnd_c;
    logic signed [SUM_W-1:0]  sum_c;
    logic signed [SW-1:0]     y_c;
    logic                     sat_c;
    logic                     at_rail;

    assign en3       = !s3_valid_reg || dout.ready;
    // feedback result is not ready until stage 2 finishes, so hold instead of forwarding
    assign s12_match = s2_valid_reg && s2_ok_reg && (s2_wr_addr_reg == s1_rd_addr_reg);
    assign hazard    = s1_valid_reg && s1_ok_reg && s12_match && (cfg.mode == MODE_FB);
    assign move12    = s1_valid_reg && (!s2_valid_reg || en3) && !hazard;
    assign din.ready = !s1_valid_reg || move12;
    assign acc       = din.valid && din.ready;

    mcf_ptr_table #(
        .CHANNELS  (CHANNELS),
        .MAX_DELAY (MAX_DELAY),
        .AW        (AW)
    ) u_ptr (
        .clk          (clk),
        .rst_n        (rst_n),
        .channel      (din.channel),
        .advance      (acc && pt_ch_ok),
        .delay_length (cfg.delay_length),
        .ch_ok        (pt_ch_ok),
        .filled       (pt_filled),
        .rd_addr      (pt_rd_addr),
        .wr_addr      (pt_wr_addr)
    );

    mcf_delay_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (pt_rd_addr),
        .rd_data (mem_rdata),
        .wr_en   (mem_we),
        .wr_addr (s2_wr_addr_reg),
        .wr_data (mem_wdata)
    );

    // catch writes that land on the slot being read, at or after the read edge
    always_comb
    begin
        byp_hit_next  = byp_hit_reg;
        byp_data_next = byp_data_reg;
        if (acc)
        begin
            byp_hit_next  = mem_we && (s2_wr_addr_reg == pt_rd_addr);
            byp_data_next = mem_wdata;
        end
        else if (s1_valid_reg && mem_we && (s2_wr_addr_reg == s1_rd_addr_reg))
        begin
            byp_hit_next  = 1'b1;
            byp_data_next = mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= byp_hit_next;
            if (acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (move12)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byp_data_next;
        if (acc)
        begin
            s1_ok_reg      <= pt_ch_ok;
            s1_filled_reg  <= pt_filled;
            s1_ch_reg      <= din.channel;
            s1_x_reg       <= din.sample_in;
            s1_rd_addr_reg <= pt_rd_addr;
            s1_wr_addr_reg <= pt_wr_addr;
        end
    end

    assign d_mem  = byp_hit_reg ? byp_data_reg : (s1_filled_reg ? mem_rdata : '0);
    assign d_sel  = s12_match ? s2_x_reg : d_mem;
    assign gain_s = cfg.gain;
    assign prod_c = gain_s * d_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_valid_reg || en3)
        begin
            s2_valid_reg <= move12;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move12)
        begin
            s2_ok_reg      <= s1_ok_reg;
            s2_ch_reg      <= s1_ch_reg;
            s2_x_reg       <= s1_x_reg;
            s2_wr_addr_reg <= s1_wr_addr_reg;
            s2_prod_reg    <= prod_c;
        end
    end

    // round half up, add, clip
    assign rnd_full = (s2_prod_reg + PROD_W'(RND_HALF)) >>> FRAC_BITS;
    assign rnd_c    = rnd_full[RND_W-1:0];
    assign sum_c    = SUM_W'(s2_x_reg) + SUM_W'(rnd_c);

    always_comb
    begin
        if (!s2_ok_reg)
        begin
            y_c   = s2_x_reg;
            sat_c = 1'b0;
        end
        else if (sum_c > SAT_HI)
        begin
            y_c   = SAT_POS;
            sat_c = 1'b1;
        end
        else if (sum_c < SAT_LO)
        begin
            y_c   = SAT_NEG;
            sat_c = 1'b1;
        end
        else
        begin
            y_c   = sum_c[SW-1:0];
            sat_c = 1'b0;
        end
    end

    assign mem_we    = s2_valid_reg && s2_ok_reg && en3;
    assign mem_wdata = (cfg.mode == MODE_FB) ? y_c : s2_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_ch_reg  <= s2_ch_reg;
            s3_y_reg   <= y_c;
            s3_sat_reg <= sat_c;
        end
    end

    assign dout.valid       = s3_valid_reg;
    assign dout.channel_out = s3_ch_reg;
    assign dout.sample_out  = s3_y_reg;
    assign dout.saturated   = s3_sat_reg;

    assign at_rail = (dout.sample_out == SAT_POS) || (dout.sample_out == SAT_NEG);

    `MCF_ASSERT_NEXT(a_accept_fills_read_stage, acc, s1_valid_reg, "accepted beat lost")
    `MCF_ASSERT_NEXT(a_write_feeds_output, mem_we, s3_valid_reg, "memory write without result")
    `MCF_ASSERT_IMPLIES(a_sat_at_rail, dout.valid && dout.saturated, at_rail, "off-rail clip")

endmodule

### design/mcf_apb_regs.sv
`timescale 1ns / 1ps
module mcf_apb_regs
    import mcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain         <= '0;
            cfg_reg.delay_length <= DLEN_W'(1);
            cfg_reg.mode         <= MODE_FF;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_GAIN:  cfg_reg.gain         <= pwdata[GAIN_W-1:0];
                REG_DELAY: cfg_reg.delay_length <= pwdata[DLEN_W-1:0];
                REG_MODE:  cfg_reg.mode         <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAIN:  prdata = APB_DW'(cfg_reg.gain);
            REG_DELAY: prdata = APB_DW'(cfg_reg.delay_length);
            REG_MODE:  prdata = APB_DW'(cfg_reg.mode);
            default:   prdata = '0;
        endcase
    end

endmodule

### design/mcf_delay_ram.sv
`timescale 1ns / 1ps
module mcf_delay_ram
    import mcf_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 16
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/mcf_ptr_table.sv
`timescale 1ns / 1ps
module mcf_ptr_table
    import mcf_pkg::*;
#(
    parameter int CHANNELS  = 8,
    parameter int MAX_DELAY = 1024,
    parameter int AW        = 13
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CH_W-1:0]   channel,
    input  logic              advance,
    input  logic [DLEN_W-1:0] delay_length,
    output logic              ch_ok,
    output logic              filled,
    output logic [AW-1:0]     rd_addr,
    output logic [AW-1:0]     wr_addr
);

    localparam int SLOT_W = $clog2(MAX_DELAY);
    localparam int DLY_W  = $clog2(MAX_DELAY + 1);
    localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [SLOT_W-1:0]   wp_reg [CHANNELS];
    logic [CHANNELS-1:0] wrap_reg;

    logic [CIW-1:0]    sel;
    logic [SLOT_W-1:0] wp;
    logic [DLY_W-1:0]  dly;
    logic [DLY_W:0]    diff;
    logic [DLY_W:0]    diff_wrapped;
    logic [SLOT_W-1:0] rd_slot;
    logic [AW-1:0]     base;

    assign ch_ok = int'(channel) < CHANNELS;
    assign sel   = ch_ok ? CIW'(channel) : '0;
    assign wp    = wp_reg[sel];

    always_comb
    begin
        if (delay_length == '0)
        begin
            dly = DLY_W'(1);
        end
        else if (int'(delay_length) > MAX_DELAY)
        begin
            dly = DLY_W'(MAX_DELAY);
        end
        else
        begin
            dly = DLY_W'(delay_length);
        end
    end

    // negative difference means the read slot lies behind the wrap point
    assign diff         = {1'b0, DLY_W'(wp)} - {1'b0, dly};
    assign diff_wrapped = diff + (DLY_W + 1)'(MAX_DELAY);
    assign rd_slot      = diff[DLY_W] ? diff_wrapped[SLOT_W-1:0] : diff[SLOT_W-1:0];

    // slots at or past the pointer are unwritten until the first wrap
    assign filled = wrap_reg[sel] || !diff[DLY_W];

    assign base    = AW'(sel) * AW'(MAX_DELAY);
    assign rd_addr = base + AW'(rd_slot);
    assign wr_addr = base + AW'(wp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i] <= '0;
            end
            wrap_reg <= '0;
        end
        else if (advance)
        begin
            if (wp == SLOT_W'(MAX_DELAY - 1))
            begin
                wp_reg[sel]   <= '0;
                wrap_reg[sel] <= 1'b1;
            end
            else
            begin
                wp_reg[sel] <= wp + 1'b1;
            end
        end
    end

endmodule
